>>> sv/aes128ctr_pkg.sv
// ----------------------------------------------------------------------------
// aes128ctr_pkg
// Shared types, reset constants and AES round functions for the CTR cipher.
// ----------------------------------------------------------------------------
package aes128ctr_pkg;

  localparam int NUM_ROUNDS     = 10;
  localparam int FIFO_DEPTH_DEF = 2;
  localparam int CFG_IDX_W      = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE0 = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE1 = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE2 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE3 = 4'd7;

  localparam logic [127:0] KEY_RESET   = 128'h1D8EBB9D_6A2E05BB_896BF69C_035A6590;
  localparam logic [127:0] NONCE_RESET = 128'hBB8BDDFB_812F8D35_6AC93AC4_112A7F82;

  typedef struct packed {
    logic [127:0] ctr;
    logic [63:0]  data_high;
    logic [63:0]  data_low;
    logic         last;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    logic [7:0] rc;
    case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1b;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[127 - 8*(i + 4*c) -: 8] = SBOX[s[127 - 8*(i + 4*((c + i) % 4)) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] t);
    logic [127:0] s;
    logic [7:0]   a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = t[127 - 32*c -: 8];
      a1 = t[119 - 32*c -: 8];
      a2 = t[111 - 32*c -: 8];
      a3 = t[103 - 32*c -: 8];
      s[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
      s[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
      s[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
      s[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
    end
    return s;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w3, t, n0, n1, n2, n3;
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = rk[127:96] ^ t;
    n1 = rk[95:64] ^ n0;
    n2 = rk[63:32] ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

>>> sv/aes128ctr_front.sv
// ----------------------------------------------------------------------------
// aes128ctr_front
// Register file, input acceptance and counter sequencing.
// ----------------------------------------------------------------------------
module aes128ctr_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aes128ctr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [63:0]                         in_block_high,
  input  logic [63:0]                         in_block_low,
  input  logic                                in_last_block,
  output logic [127:0]                        key,
  output logic                                push,
  output aes128ctr_pkg::job_t                 push_job,
  input  logic                                q_full
);
  import aes128ctr_pkg::*;

  logic [127:0] key_r, key_nxt;
  logic [127:0] nonce_r, nonce_nxt;
  logic [127:0] ctr_r, ctr_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign key       = key_r;

  assign push_job.ctr       = ctr_r;
  assign push_job.data_high = in_block_high;
  assign push_job.data_low  = in_block_low;
  assign push_job.last      = in_last_block;

  always_comb begin
    key_nxt   = key_r;
    nonce_nxt = nonce_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_KEY0:   key_nxt[127:96]   = cfg_data;
        REG_KEY1:   key_nxt[95:64]    = cfg_data;
        REG_KEY2:   key_nxt[63:32]    = cfg_data;
        REG_KEY3:   key_nxt[31:0]     = cfg_data;
        REG_NONCE0: nonce_nxt[127:96] = cfg_data;
        REG_NONCE1: nonce_nxt[95:64]  = cfg_data;
        REG_NONCE2: nonce_nxt[63:32]  = cfg_data;
        REG_NONCE3: nonce_nxt[31:0]   = cfg_data;
        default: ;
      endcase
    end
  end

  // a last item restarts the counter from the nonce
  always_comb begin
    ctr_nxt = ctr_r;
    if (push) begin
      ctr_nxt = in_last_block ? nonce_r : ctr_r + 128'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= KEY_RESET;
      nonce_r <= NONCE_RESET;
      ctr_r   <= NONCE_RESET;
    end else begin
      key_r   <= key_nxt;
      nonce_r <= nonce_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

endmodule

>>> sv/aes128ctr_fifo.sv
// ----------------------------------------------------------------------------
// aes128ctr_fifo
// Short job queue between the front and the cipher back end.
// ----------------------------------------------------------------------------
module aes128ctr_fifo #(
  parameter int DEPTH = aes128ctr_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  aes128ctr_pkg::job_t push_job,
  output logic                full,
  input  logic                pop,
  output logic                q_valid,
  output aes128ctr_pkg::job_t q_job
);
  import aes128ctr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_job   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> sv/aes128ctr_back.sv
// ----------------------------------------------------------------------------
// aes128ctr_back
// Iterative AES-128 core, one round a cycle (the final round waits while the
// result register is held), with keystream XOR and result register.
// ----------------------------------------------------------------------------
module aes128ctr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [127:0]        key,
  input  logic                q_valid,
  input  aes128ctr_pkg::job_t q_job,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [63:0]         out_result_high,
  output logic [63:0]         out_result_low,
  output logic                out_result_last
);
  import aes128ctr_pkg::*;

  localparam logic [3:0] LAST_ROUND = 4'(NUM_ROUNDS);

  logic         busy_r, busy_nxt;
  logic [3:0]   round_r, round_nxt;
  logic [127:0] st_r, st_nxt;
  logic [127:0] rk_r, rk_nxt;
  logic [127:0] data_r;
  logic         last_r;
  logic         ov_r, ov_nxt;
  logic [127:0] res_r;
  logic         res_last_r;
  logic [127:0] rk_step, sb, st_step;
  logic         finish;

  assign rk_step = key_next(rk_r, rcon(round_r));
  assign sb      = sub_shift(st_r);
  assign st_step = ((round_r == LAST_ROUND) ? sb : mix_columns(sb)) ^ rk_step;

  // final round waits while the result register is still held
  assign finish = busy_r && (round_r == LAST_ROUND) && (!ov_r || !out_stall);
  assign pop    = q_valid && (!busy_r || finish);

  always_comb begin
    busy_nxt  = busy_r;
    round_nxt = round_r;
    st_nxt    = st_r;
    rk_nxt    = rk_r;
    ov_nxt    = ov_r;
    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
    if (finish) begin
      ov_nxt   = 1'b1;
      busy_nxt = 1'b0;
    end else if (busy_r && round_r != LAST_ROUND) begin
      round_nxt = round_r + 4'd1;
      st_nxt    = st_step;
      rk_nxt    = rk_step;
    end
    if (pop) begin
      busy_nxt  = 1'b1;
      round_nxt = 4'd1;
      st_nxt    = q_job.ctr ^ key;
      rk_nxt    = key;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      data_r <= {q_job.data_high, q_job.data_low};
      last_r <= q_job.last;
    end
    if (finish) begin
      res_r      <= data_r ^ st_step;
      res_last_r <= last_r;
    end
    st_r <= st_nxt;
    rk_r <= rk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      round_r <= round_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];
  assign out_result_last = res_last_r;

endmodule

>>> sv/aes128_ctr_block_cipher.sv
// ----------------------------------------------------------------------------
// aes128_ctr_block_cipher
// AES-128 counter-mode cipher: front end sequences the counter, back end runs
// the rounds and XORs the keystream into each item.
// ----------------------------------------------------------------------------
// channel  handshake           payload
// in       in_valid/in_stall   in_block_high, in_block_low, in_last_block
// out      out_valid/out_stall out_result_high, out_result_low, out_result_last
// cfg      cfg_valid/cfg_ready cfg_index (0-3 key, 4-7 nonce), cfg_data
//
// each item passes the round unit one round a cycle, the final round waiting while
// the output holds the result; the initial key addition is folded into the cycle
// that loads the counter. the unit holds one item and takes the next as it finishes.
// an accepted item passes the queue, the round state and the result register.
// synchronous reset restores key, nonce and counter; no clearing pass.
// the queue keeps accepting items while the round unit or the output stalls,
// until its FIFO_DEPTH entries (two by default) are taken; then the input stalls.
// ----------------------------------------------------------------------------
module aes128_ctr_block_cipher #(
  parameter int FIFO_DEPTH = aes128ctr_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aes128ctr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [63:0]                         in_block_high,
  input  logic [63:0]                         in_block_low,
  input  logic                                in_last_block,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [63:0]                         out_result_high,
  output logic [63:0]                         out_result_low,
  output logic                                out_result_last
);
  import aes128ctr_pkg::*;

  logic [127:0] key;
  logic         push, q_full, pop, q_valid;
  job_t         push_job, q_job;

  aes128ctr_front u_front (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .in_block_high, .in_block_low, .in_last_block,
    .key, .push, .push_job, .q_full
  );

  aes128ctr_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n,
    .push, .push_job, .full(q_full),
    .pop, .q_valid, .q_job
  );

  aes128ctr_back u_back (
    .clk, .rst_n,
    .key, .q_valid, .q_job, .pop,
    .out_valid, .out_stall, .out_result_high, .out_result_low, .out_result_last
  );

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the AES-128 counter-mode cipher: a local AES model
// follows key, nonce and counter, and every item out of the block is checked
// against it under random idling, a long output hold-off and config changes.
// ----------------------------------------------------------------------------
module tb_top;
  import aes128ctr_pkg::*;

  typedef struct {
    logic [63:0] res_hi;
    logic [63:0] res_lo;
    logic        res_last;
  } ctr_result_t;

  localparam int STALL_PCT   = 28;
  localparam int HOLD_CYCLES = 400;
  localparam int WDOG_LIMIT  = 5000;
  localparam int SETTLE      = 30;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [63:0]          in_block_high;
  logic [63:0]          in_block_low;
  logic                 in_last_block;
  logic                 out_valid;
  logic                 out_stall;
  logic [63:0]          out_result_high;
  logic [63:0]          out_result_low;
  logic                 out_result_last;

  logic [7:0]   sub_table [256];
  logic [31:0]  key_regs [4];
  logic [31:0]  nonce_regs [4];
  logic [127:0] counter_val;
  ctr_result_t  pending_results [$];
  int           fail_count;
  int           idle_cycles;
  bit           quiet_mode;
  bit           hold_request;
  int           hold_left;

  aes128_ctr_block_cipher DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_block_high(in_block_high),
    .in_block_low(in_block_low), .in_last_block(in_last_block),
    .out_valid(out_valid), .out_stall(out_stall), .out_result_high(out_result_high),
    .out_result_low(out_result_low), .out_result_last(out_result_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] gf_double(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // substitution table built from the field inverse and the affine map
  task automatic build_sub_table();
    logic [7:0] p, q;
    p = 8'h01;
    q = 8'h01;
    do begin
      p = p ^ gf_double(p);
      q = q ^ (q << 1);
      q = q ^ (q << 2);
      q = q ^ (q << 4);
      if (q[7]) q = q ^ 8'h09;
      sub_table[p] = q ^ rotl8(q, 1) ^ rotl8(q, 2) ^ rotl8(q, 3) ^ rotl8(q, 4) ^ 8'h63;
    end while (p != 8'h01);
    sub_table[0] = 8'h63;
  endtask

  function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                               input logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] sh [16];
    logic [7:0] w [4];
    logic [7:0] f, a0, a1, a2, a3, rc;
    logic [127:0] res;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[127 - 8*i -: 8];
    for (int i = 4; i < 44; i++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1) + j];
      if (i % 4 == 0) begin
        f    = w[0];
        w[0] = sub_table[w[1]] ^ rc;
        w[1] = sub_table[w[2]];
        w[2] = sub_table[w[3]];
        w[3] = sub_table[f];
        rc   = gf_double(rc);
      end
      for (int j = 0; j < 4; j++) rk[4*i + j] = rk[4*(i-4) + j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] = blk[127 - 8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) sh[i + 4*c] = sub_table[st[i + 4*((c + i) % 4)]];
      for (int c = 0; c < 4; c++) begin
        a0 = sh[4*c];
        a1 = sh[4*c+1];
        a2 = sh[4*c+2];
        a3 = sh[4*c+3];
        if (r < 10) begin
          st[4*c]   = gf_double(a0 ^ a1) ^ a1 ^ a2 ^ a3;
          st[4*c+1] = gf_double(a1 ^ a2) ^ a0 ^ a2 ^ a3;
          st[4*c+2] = gf_double(a2 ^ a3) ^ a0 ^ a1 ^ a3;
          st[4*c+3] = gf_double(a3 ^ a0) ^ a0 ^ a1 ^ a2;
        end else begin
          st[4*c]   = a0;
          st[4*c+1] = a1;
          st[4*c+2] = a2;
          st[4*c+3] = a3;
        end
      end
      for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[16*r + i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return res;
  endfunction

  // predictor and result checker, all sampled at the rising edge
  always @(posedge clk) begin
    ctr_result_t exp_res;
    logic [127:0] keystream;
    if (!rst_n) begin
      key_regs    = '{KEY_RESET[127:96], KEY_RESET[95:64], KEY_RESET[63:32], KEY_RESET[31:0]};
      nonce_regs  = '{NONCE_RESET[127:96], NONCE_RESET[95:64], NONCE_RESET[63:32],
                      NONCE_RESET[31:0]};
      counter_val = NONCE_RESET;
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (cfg_valid && cfg_ready) begin
        idle_cycles = 0;
        case (cfg_index)
          REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3:
            key_regs[cfg_index[1:0]] = cfg_data;
          REG_NONCE0, REG_NONCE1, REG_NONCE2, REG_NONCE3:
            nonce_regs[cfg_index[1:0]] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        keystream = aes_encrypt({key_regs[0], key_regs[1], key_regs[2], key_regs[3]},
                                counter_val);
        exp_res.res_hi   = in_block_high ^ keystream[127:64];
        exp_res.res_lo   = in_block_low ^ keystream[63:0];
        exp_res.res_last = in_last_block;
        pending_results.push_back(exp_res);
        if (in_last_block)
          counter_val = {nonce_regs[0], nonce_regs[1], nonce_regs[2], nonce_regs[3]};
        else
          counter_val = counter_val + 128'd1;
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected item: hi=%h lo=%h last=%b",
                     out_result_high, out_result_low, out_result_last);
        end else begin
          exp_res = pending_results.pop_front();
          if (out_result_high !== exp_res.res_hi || out_result_low !== exp_res.res_lo ||
              out_result_last !== exp_res.res_last) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp hi=%h lo=%h last=%b  got hi=%h lo=%h last=%b",
                       exp_res.res_hi, exp_res.res_lo, exp_res.res_last,
                       out_result_high, out_result_low, out_result_last);
          end
        end
      end
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: random stalls, quiet stretches and long hold-offs on request
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (quiet_mode) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < STALL_PCT);
    end
  end

  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic last);
    while (!quiet_mode && $urandom_range(0, 99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_block_high <= hi;
    in_block_low  <= lo;
    in_last_block <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_key(input logic [127:0] k);
    write_reg(REG_KEY0, k[127:96]);
    write_reg(REG_KEY1, k[95:64]);
    write_reg(REG_KEY2, k[63:32]);
    write_reg(REG_KEY3, k[31:0]);
  endtask

  task automatic write_nonce(input logic [127:0] n);
    write_reg(REG_NONCE0, n[127:96]);
    write_reg(REG_NONCE1, n[95:64]);
    write_reg(REG_NONCE2, n[63:32]);
    write_reg(REG_NONCE3, n[31:0]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic test_reset_values();
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
    send_block('0, '0, 1'b0);
    drain();
  endtask

  task automatic test_key_extremes();
    write_key('0);
    send_block(rand64(), rand64(), 1'b0);
    send_block('0, '0, 1'b1);
    drain();
    write_key('1);
    send_block('1, '0, 1'b0);
    send_block(rand64(), rand64(), 1'b1);
    drain();
  endtask

  task automatic test_counter_wrap();
    // nonce change alone must not touch the running count
    write_nonce('1);
    send_block(rand64(), rand64(), 1'b0);
    send_block(rand64(), rand64(), 1'b1);
    // full 128-bit wrap to zero
    send_block('0, '0, 1'b0);
    send_block('0, '0, 1'b0);
    send_block('0, '0, 1'b1);
    drain();
    // carry out of the low half only
    write_nonce({64'h0123456789abcdef, 64'hffffffffffffffff});
    send_block(rand64(), rand64(), 1'b1);
    send_block('0, '0, 1'b0);
    send_block('0, '0, 1'b0);
    drain();
    // indexes past the last register are ignored
    write_reg(4'd8, 32'hdeadbeef);
    write_reg(4'd15, '1);
    send_block(rand64(), rand64(), 1'b1);
    drain();
  endtask

  task automatic test_random_traffic();
    int kind;
    for (int phase = 0; phase < 4; phase++) begin
      kind = $urandom_range(0, 2);
      write_key(kind == 0 ? '0 : kind == 1 ? '1 : {rand64(), rand64()});
      kind = $urandom_range(0, 2);
      write_nonce(kind == 0 ? {64'h0, 64'hfffffffffffffffe} :
                  kind == 1 ? '1 : {rand64(), rand64()});
      send_block(rand64(), rand64(), 1'b1);
      for (int n = 0; n < 420; n++) begin
        quiet_mode   = (phase == 1 && n >= 100 && n < 250);
        hold_request = (phase == 2 && n == 50);
        send_block(rand64(), rand64(), $urandom_range(0, 15) == 0);
      end
      quiet_mode   = 1'b0;
      hold_request = 1'b0;
      drain();
    end
  endtask

  initial begin
    fail_count    = 0;
    quiet_mode    = 1'b0;
    hold_request  = 1'b0;
    hold_left     = 0;
    rst_n         <= 1'b0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    in_block_high <= '0;
    in_block_low  <= '0;
    in_last_block <= 1'b0;
    out_stall     <= 1'b0;
    build_sub_table();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_key_extremes();
    test_counter_wrap();
    test_random_traffic();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

>>> aes128_ctr_block_cipher.f
sv/aes128ctr_pkg.sv
sv/aes128ctr_front.sv
sv/aes128ctr_fifo.sv
sv/aes128ctr_back.sv
sv/aes128_ctr_block_cipher.sv
tb/tb_top.sv
